### rtl/sgrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgrm_pkg: shared types and constants of the stereo gain ramp meter
// Widths, register indexes, reset values and the structs that travel between
// the front end, the step divider, the frame queue and the back end.
// ----------------------------------------------------------------------------
package sgrm_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int GAIN_FRAC     = 23;
	localparam int GAIN_BITS     = GAIN_FRAC + 2;
	localparam int TARGET_BITS   = 16;
	localparam int TARGET_SHIFT  = GAIN_FRAC - 15;
	localparam int RAMP_BITS     = 16;
	localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS;
	localparam int WIDE_BITS     = PROD_BITS - GAIN_FRAC;
	localparam int DIV_CNT_BITS  = $clog2(GAIN_BITS + 1);
	localparam int MID_DEPTH     = 4;
	localparam int MID_PTR_BITS  = $clog2(MID_DEPTH);
	localparam int OUT_DEPTH     = 4;
	localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_BITS  = OUT_PTR_BITS + 1;
	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [TARGET_BITS-1:0] UNITY_Q15 = 16'h8000;
	localparam logic signed [GAIN_BITS-1:0] UNITY_GAIN =
		GAIN_BITS'({UNITY_Q15, {TARGET_SHIFT{1'b0}}});

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_GAIN     = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_FRAMES     = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MONO_OUTPUT     = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_METERING_ENABLE = 8'd3;

	localparam logic [TARGET_BITS-1:0] RST_TARGET_GAIN = UNITY_Q15;
	localparam logic [RAMP_BITS-1:0]   RST_RAMP_FRAMES = 16'd240;

	typedef struct packed {
		logic [TARGET_BITS-1:0] target_gain;
		logic [RAMP_BITS-1:0]   ramp_frames;
		logic                   mono_output;
		logic                   metering_enable;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          last;
		logic signed [GAIN_BITS-1:0]   gain;
	} mid_entry_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
		logic [SAMPLE_BITS-1:0]        input_level_peak;
		logic [SAMPLE_BITS-1:0]        output_level_peak;
		logic                          buffer_end;
	} result_t;

	typedef struct packed {
		logic                 start;
		logic [GAIN_BITS-1:0] num;
		logic [RAMP_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [GAIN_BITS-1:0] quo;
	} div_rsp_t;

	typedef enum logic {
		FS_ACCEPT,
		FS_DIVIDE
	} front_state_t;

endpackage
`default_nettype wire

### rtl/sgrm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgrm_div: radix-2 restoring divider for the ramp step
// Unsigned magnitude divided by the ramp length, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sgrm_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sgrm_pkg::div_req_t  req,
	output sgrm_pkg::div_rsp_t       rsp
);
	import sgrm_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [GAIN_BITS-1:0]    quo_q;
	logic [RAMP_BITS-1:0]    rem_q;
	logic [RAMP_BITS-1:0]    den_q;
	logic [RAMP_BITS:0]      rem_sh;
	logic [RAMP_BITS:0]      rem_sub;
	logic                    fits;

	assign rem_sh  = {rem_q, quo_q[GAIN_BITS-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(GAIN_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit is dropped
			rem_q <= fits ? rem_sub[RAMP_BITS-1:0] : rem_sh[RAMP_BITS-1:0];
			quo_q <= {quo_q[GAIN_BITS-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a division in progress");

endmodule
`default_nettype wire

### rtl/sgrm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgrm_front: frame intake and gain ramp
// Latches the target at buffer start, computes the ramp step through the
// divider, advances the running gain and queues each frame with its gain.
// ----------------------------------------------------------------------------
module sgrm_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic signed [sgrm_pkg::SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [sgrm_pkg::SAMPLE_BITS-1:0] right_sample,
	input  wire logic                                   last_frame,
	input  wire sgrm_pkg::cfg_t                         cfg,
	input  wire logic                                   mid_full,
	output logic                                        mid_push,
	output sgrm_pkg::mid_entry_t                        mid_data,
	output sgrm_pkg::div_req_t                          div_req,
	input  wire sgrm_pkg::div_rsp_t                     div_rsp
);
	import sgrm_pkg::*;

	front_state_t state_q, state_d;

	logic signed [GAIN_BITS-1:0]   running_gain_q;
	logic [TARGET_BITS-1:0]        latched_target_q;
	logic signed [GAIN_BITS-1:0]   ramp_step_q;
	logic [RAMP_BITS-1:0]          ramp_left_q;
	logic                          at_start_q;
	logic                          neg_q;
	logic signed [SAMPLE_BITS-1:0] hold_left_q;
	logic signed [SAMPLE_BITS-1:0] hold_right_q;
	logic                          hold_last_q;

	logic                          accept;
	logic [TARGET_BITS-1:0]        t_clamp;
	logic [RAMP_BITS-1:0]          n_eff;
	logic                          need_div;
	logic signed [GAIN_BITS-1:0]   target23;
	logic signed [GAIN_BITS-1:0]   new_target23;
	logic signed [GAIN_BITS-1:0]   diff;
	logic signed [GAIN_BITS-1:0]   step_div;
	logic signed [GAIN_BITS-1:0]   step_sel;
	logic [RAMP_BITS-1:0]          left_dec;
	logic [RAMP_BITS-1:0]          left_upd;
	logic signed [GAIN_BITS-1:0]   gain_upd;

	assign accept   = push && !full;
	assign t_clamp  = (cfg.target_gain > UNITY_Q15) ? UNITY_Q15 : cfg.target_gain;
	assign n_eff    = (cfg.ramp_frames == '0) ? RAMP_BITS'(1) : cfg.ramp_frames;
	assign need_div = at_start_q && (t_clamp != latched_target_q);

	assign target23     = GAIN_BITS'({latched_target_q, {TARGET_SHIFT{1'b0}}});
	assign new_target23 = GAIN_BITS'({t_clamp, {TARGET_SHIFT{1'b0}}});
	assign diff         = new_target23 - running_gain_q;

	assign div_req.start = accept && need_div;
	assign div_req.num   = diff[GAIN_BITS-1] ? GAIN_BITS'(-diff) : GAIN_BITS'(diff);
	assign div_req.den   = n_eff;

	// truncation toward zero: divide magnitudes, restore the sign
	assign step_div = neg_q ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
	assign step_sel = (state_q == FS_DIVIDE) ? step_div : ramp_step_q;

	always_comb begin
		left_dec = ramp_left_q - RAMP_BITS'(1);
		if (ramp_left_q == '0) begin
			left_upd = '0;
			gain_upd = running_gain_q;
		end else begin
			left_upd = left_dec;
			// the last ramp frame lands exactly on the target
			gain_upd = (left_dec != '0) ? running_gain_q + step_sel : target23;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_ACCEPT: begin
				if (accept && need_div) begin
					state_d = FS_DIVIDE;
				end
			end
			FS_DIVIDE: begin
				if (div_rsp.done) begin
					state_d = FS_ACCEPT;
				end
			end
			default: state_d = FS_ACCEPT;
		endcase
	end

	always_comb begin
		full           = 1'b1;
		mid_push       = 1'b0;
		mid_data.left  = left_sample;
		mid_data.right = right_sample;
		mid_data.last  = last_frame;
		mid_data.gain  = gain_upd;
		unique case (state_q)
			FS_ACCEPT: begin
				full     = mid_full;
				mid_push = accept && !need_div;
			end
			FS_DIVIDE: begin
				mid_push       = div_rsp.done;
				mid_data.left  = hold_left_q;
				mid_data.right = hold_right_q;
				mid_data.last  = hold_last_q;
			end
			default: begin
				full = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= FS_ACCEPT;
			running_gain_q   <= '0;
			latched_target_q <= '0;
			ramp_step_q      <= '0;
			ramp_left_q      <= '0;
			at_start_q       <= 1'b1;
			neg_q            <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				at_start_q <= last_frame;
			end
			if (accept && need_div) begin
				latched_target_q <= t_clamp;
				ramp_left_q      <= n_eff;
				neg_q            <= diff[GAIN_BITS-1];
			end else if (mid_push) begin
				running_gain_q <= gain_upd;
				ramp_left_q    <= left_upd;
				if (state_q == FS_DIVIDE) begin
					ramp_step_q <= step_div;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && need_div) begin
			hold_left_q  <= left_sample;
			hold_right_q <= right_sample;
			hold_last_q  <= last_frame;
		end
	end

	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == FS_DIVIDE))
		else $error("step ready while front end not waiting for it");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		!running_gain_q[GAIN_BITS-1] && (running_gain_q <= UNITY_GAIN))
		else $error("running gain outside zero to unity");

endmodule
`default_nettype wire

### rtl/sgrm_mid_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgrm_mid_q: frame queue between front end and back end
// Small register queue of frames tagged with their gain.
// ----------------------------------------------------------------------------
module sgrm_mid_q (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire sgrm_pkg::mid_entry_t  data_in,
	output logic                       full,
	input  wire logic                  pop,
	output sgrm_pkg::mid_entry_t       head,
	output logic                       empty
);
	import sgrm_pkg::*;

	mid_entry_t              mem_q [MID_DEPTH];
	logic [MID_PTR_BITS-1:0] wr_ptr_q;
	logic [MID_PTR_BITS-1:0] rd_ptr_q;
	logic [MID_PTR_BITS:0]   cnt_q;
	logic                    do_push;
	logic                    do_pop;

	assign full    = cnt_q == (MID_PTR_BITS + 1)'(MID_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + MID_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + MID_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (MID_PTR_BITS + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (MID_PTR_BITS + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

endmodule
`default_nettype wire

### rtl/sgrm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgrm_back: gain multiply, mono mix, saturation and peak metering
// Two pipeline stages feed a result queue; frames are drawn from the frame
// queue only when the result queue has room for everything in flight.
// ----------------------------------------------------------------------------
module sgrm_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sgrm_pkg::cfg_t        cfg,
	input  wire logic                  meter_clr,
	input  wire sgrm_pkg::mid_entry_t  mid_head,
	input  wire logic                  mid_empty,
	output logic                       mid_pop,
	input  wire logic                  pop,
	output logic                       empty,
	output sgrm_pkg::result_t          res_head
);
	import sgrm_pkg::*;

	function automatic logic [SAMPLE_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
		logic [SAMPLE_BITS-1:0] r;
		r = v[SAMPLE_BITS-1] ? (SAMPLE_BITS'(~v) + SAMPLE_BITS'(1)) : SAMPLE_BITS'(v);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WIDE_BITS-1:0] v);
		logic                          in_range;
		logic signed [SAMPLE_BITS-1:0] r;
		in_range = v[WIDE_BITS-1:SAMPLE_BITS-1] ==
			{(WIDE_BITS - SAMPLE_BITS + 1){v[SAMPLE_BITS-1]}};
		r = in_range ? v[SAMPLE_BITS-1:0] :
			{v[WIDE_BITS-1], {(SAMPLE_BITS - 1){~v[WIDE_BITS-1]}}};
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] max3(input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b, input logic [SAMPLE_BITS-1:0] c);
		logic [SAMPLE_BITS-1:0] m;
		m = (b > a) ? b : a;
		m = (c > m) ? c : m;
		return m;
	endfunction

	// stage 1: products
	logic                          v_s1;
	logic signed [PROD_BITS-1:0]   prod_l_s1;
	logic signed [PROD_BITS-1:0]   prod_r_s1;
	logic [SAMPLE_BITS-1:0]        imag_l_s1;
	logic [SAMPLE_BITS-1:0]        imag_r_s1;
	logic                          last_s1;
	// stage 2: output samples
	logic                          v_s2;
	logic signed [SAMPLE_BITS-1:0] out_l_s2;
	logic signed [SAMPLE_BITS-1:0] out_r_s2;
	logic [SAMPLE_BITS-1:0]        imag_l_s2;
	logic [SAMPLE_BITS-1:0]        imag_r_s2;
	logic                          last_s2;

	logic [SAMPLE_BITS-1:0]        in_peak_q;
	logic [SAMPLE_BITS-1:0]        out_peak_q;

	result_t                       res_q [OUT_DEPTH];
	logic [OUT_PTR_BITS-1:0]       res_wr_q;
	logic [OUT_PTR_BITS-1:0]       res_rd_q;
	logic [OUT_CNT_BITS-1:0]       res_cnt_q;
	logic [OUT_CNT_BITS:0]         occ;
	logic                          res_pop;

	logic signed [WIDE_BITS-1:0]   wide_l;
	logic signed [WIDE_BITS-1:0]   wide_r;
	logic signed [WIDE_BITS:0]     mix_sum;
	logic signed [WIDE_BITS-1:0]   sel_l;
	logic signed [WIDE_BITS-1:0]   sel_r;

	logic [SAMPLE_BITS-1:0]        in_peak_new;
	logic [SAMPLE_BITS-1:0]        out_peak_new;
	result_t                       res_new;

	// credit check: queued plus in-flight results never exceed the queue
	assign occ     = (OUT_CNT_BITS + 1)'(res_cnt_q) + (OUT_CNT_BITS + 1)'(v_s1)
		+ (OUT_CNT_BITS + 1)'(v_s2);
	assign mid_pop = !mid_empty && (occ < (OUT_CNT_BITS + 1)'(OUT_DEPTH));

	// floor shift of the product is an arithmetic part-select
	assign wide_l  = $signed(prod_l_s1[PROD_BITS-1:GAIN_FRAC]);
	assign wide_r  = $signed(prod_r_s1[PROD_BITS-1:GAIN_FRAC]);
	assign mix_sum = {wide_l[WIDE_BITS-1], wide_l} + {wide_r[WIDE_BITS-1], wide_r};

	always_comb begin
		if (cfg.mono_output) begin
			sel_l = $signed(mix_sum[WIDE_BITS:1]);
			sel_r = $signed(mix_sum[WIDE_BITS:1]);
		end else begin
			sel_l = wide_l;
			sel_r = wide_r;
		end
	end

	always_comb begin
		in_peak_new            = max3(in_peak_q, imag_l_s2, imag_r_s2);
		out_peak_new           = max3(out_peak_q, mag(out_l_s2), mag(out_r_s2));
		res_new.out_left       = out_l_s2;
		res_new.out_right      = out_r_s2;
		res_new.buffer_end     = last_s2;
		res_new.input_level_peak  = '0;
		res_new.output_level_peak = '0;
		if (cfg.metering_enable && last_s2) begin
			res_new.input_level_peak  = in_peak_new;
			res_new.output_level_peak = out_peak_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			in_peak_q  <= '0;
			out_peak_q <= '0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
			if (meter_clr) begin
				in_peak_q  <= '0;
				out_peak_q <= '0;
			end else if (v_s2 && cfg.metering_enable) begin
				in_peak_q  <= last_s2 ? '0 : in_peak_new;
				out_peak_q <= last_s2 ? '0 : out_peak_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			prod_l_s1 <= PROD_BITS'(mid_head.left) * PROD_BITS'(mid_head.gain);
			prod_r_s1 <= PROD_BITS'(mid_head.right) * PROD_BITS'(mid_head.gain);
			imag_l_s1 <= mag(mid_head.left);
			imag_r_s1 <= mag(mid_head.right);
			last_s1   <= mid_head.last;
		end
		if (v_s1) begin
			out_l_s2  <= sat(sel_l);
			out_r_s2  <= sat(sel_r);
			imag_l_s2 <= imag_l_s1;
			imag_r_s2 <= imag_r_s1;
			last_s2   <= last_s1;
		end
	end

	// result queue
	assign empty    = res_cnt_q == '0;
	assign res_pop  = pop && !empty;
	assign res_head = res_q[res_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (v_s2) begin
				res_wr_q <= res_wr_q + OUT_PTR_BITS'(1);
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + OUT_PTR_BITS'(1);
			end
			if (v_s2 && !res_pop) begin
				res_cnt_q <= res_cnt_q + OUT_CNT_BITS'(1);
			end else if (res_pop && !v_s2) begin
				res_cnt_q <= res_cnt_q - OUT_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (res_cnt_q < OUT_CNT_BITS'(OUT_DEPTH)) || res_pop)
		else $error("result queue written while full");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (OUT_CNT_BITS + 1)'(OUT_DEPTH))
		else $error("more words in flight than result queue slots");

endmodule
`default_nettype wire

### rtl/stereo_gain_ramp_meter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_gain_ramp_meter_core: smoothed stereo gain with mono mix and metering
// Frames enter through a queue-style push/full port and results leave through
// an empty/pop port, one result word per frame, in order.
// Usage:
//   - push a frame while full is low; read the result word while empty is low
//     and take it with pop.
//   - a frame that is not a buffer start with a changed target goes straight
//     into the frame queue; its result passes the product and output stages.
//   - a buffer start with a changed target runs the ramp-step divider, one
//     quotient bit per cycle, so the front end holds full high until the
//     divider is done and only then queues that frame with its gain.
//   - write registers over cfg_valid/cfg_ready/cfg_index/cfg_data only while
//     no frame is in flight; cfg_ready is always high. Writing the metering
//     register clears both peak accumulators.
//   - a receiver that stops popping fills the four-word result queue, then
//     the four-word frame queue, after which full goes high.
//   - reset empties both queues, zeroes the running gain and ramp, marks the
//     next frame as a buffer start and loads the register defaults.
// ----------------------------------------------------------------------------
module stereo_gain_ramp_meter_core (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic signed [sgrm_pkg::SAMPLE_BITS-1:0]  left_sample,
	input  wire logic signed [sgrm_pkg::SAMPLE_BITS-1:0]  right_sample,
	input  wire logic                                    last_frame,
	output logic                                         empty,
	input  wire logic                                    pop,
	output logic signed [sgrm_pkg::SAMPLE_BITS-1:0]       out_left,
	output logic signed [sgrm_pkg::SAMPLE_BITS-1:0]       out_right,
	output logic [sgrm_pkg::SAMPLE_BITS-1:0]              input_level_peak,
	output logic [sgrm_pkg::SAMPLE_BITS-1:0]              output_level_peak,
	output logic                                         buffer_end,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [sgrm_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  wire logic [sgrm_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
	import sgrm_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic       meter_clr;
	logic       mid_full;
	logic       mid_push;
	logic       mid_pop;
	logic       mid_empty;
	mid_entry_t mid_in;
	mid_entry_t mid_head;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	result_t    res_head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign meter_clr = cfg_wr && (cfg_index == REG_METERING_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_gain     <= RST_TARGET_GAIN;
			cfg_q.ramp_frames     <= RST_RAMP_FRAMES;
			cfg_q.mono_output     <= 1'b0;
			cfg_q.metering_enable <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_TARGET_GAIN:     cfg_q.target_gain     <= cfg_data[TARGET_BITS-1:0];
				REG_RAMP_FRAMES:     cfg_q.ramp_frames     <= cfg_data[RAMP_BITS-1:0];
				REG_MONO_OUTPUT:     cfg_q.mono_output     <= cfg_data[0];
				REG_METERING_ENABLE: cfg_q.metering_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sgrm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_frame   (last_frame),
		.cfg          (cfg_q),
		.mid_full     (mid_full),
		.mid_push     (mid_push),
		.mid_data     (mid_in),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	sgrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sgrm_mid_q u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.data_in (mid_in),
		.full    (mid_full),
		.pop     (mid_pop),
		.head    (mid_head),
		.empty   (mid_empty)
	);

	sgrm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.meter_clr (meter_clr),
		.mid_head  (mid_head),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.res_head  (res_head)
	);

	assign out_left          = res_head.out_left;
	assign out_right         = res_head.out_right;
	assign input_level_peak  = res_head.input_level_peak;
	assign output_level_peak = res_head.output_level_peak;
	assign buffer_end        = res_head.buffer_end;

endmodule
`default_nettype wire

### tb/tb_stereo_gain_ramp_meter_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_gain_ramp_meter_core: self-checking bench for the gain ramp meter
// Frames are fed through the push/full port from a queue and every popped
// result word is compared field by field against a cycle-free model of the
// ramp, the Q1.23 gain, the mono mix and the buffer peak meters. Register
// writes happen between phases once the block has drained. Phases mix
// directed extremes with random buffers under varying sender and receiver
// idling, including one long receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_stereo_gain_ramp_meter_core;
	import sgrm_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam int TOTAL_FRAMES = 750;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          last;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [SAMPLE_BITS-1:0] left_sample = '0;
	logic signed [SAMPLE_BITS-1:0] right_sample = '0;
	logic last_frame = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic [SAMPLE_BITS-1:0] input_level_peak;
	logic [SAMPLE_BITS-1:0] output_level_peak;
	logic buffer_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// register copies
	logic [TARGET_BITS-1:0] reg_target = RST_TARGET_GAIN;
	logic [RAMP_BITS-1:0] reg_ramp = RST_RAMP_FRAMES;
	logic reg_mono = 1'b0;
	logic reg_meter = 1'b0;

	// gain and meter state
	logic signed [GAIN_BITS-1:0] run_gain = '0;
	logic signed [GAIN_BITS-1:0] gain_step = '0;
	logic [TARGET_BITS-1:0] held_target = '0;
	logic [RAMP_BITS-1:0] ramp_cnt = '0;
	logic buf_start = 1'b1;
	logic [SAMPLE_BITS-1:0] in_peak = '0;
	logic [SAMPLE_BITS-1:0] out_peak = '0;

	frame_t frames_to_send[$];
	result_t expected_results[$];
	frame_t tx_frame;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_start = 1'b0;
	logic recv_hold = 1'b0;
	int mismatch_count = 0;
	int frames_queued = 0;

	stereo_gain_ramp_meter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.last_frame(last_frame),
		.empty(empty),
		.pop(pop),
		.out_left(out_left),
		.out_right(out_right),
		.input_level_peak(input_level_peak),
		.output_level_peak(output_level_peak),
		.buffer_end(buffer_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint clamp_sample(longint v);
		if (v > longint'(S_MAX))
			return longint'(S_MAX);
		if (v < longint'(S_MIN))
			return longint'(S_MIN);
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// advances the ramp by one frame and returns the word this frame produces
	function automatic result_t apply_gain(frame_t f);
		longint l_in, r_in, tgt, n, l, r;
		logic [TARGET_BITS-1:0] t;
		result_t res;
		l_in = f.left;
		r_in = f.right;
		tgt = longint'(held_target) << TARGET_SHIFT;
		if (buf_start) begin
			t = (reg_target > UNITY_Q15) ? UNITY_Q15 : reg_target;
			if (t != held_target) begin
				n = (reg_ramp == 0) ? 1 : longint'(reg_ramp);
				held_target = t;
				tgt = longint'(t) << TARGET_SHIFT;
				ramp_cnt = RAMP_BITS'(n);
				gain_step = GAIN_BITS'((tgt - longint'(run_gain)) / n);
			end
		end
		if (ramp_cnt != 0) begin
			ramp_cnt = ramp_cnt - RAMP_BITS'(1);
			if (ramp_cnt != 0)
				run_gain = run_gain + gain_step;
			else
				run_gain = GAIN_BITS'(tgt);
		end
		l = (l_in * longint'(run_gain)) >>> GAIN_FRAC;
		r = (r_in * longint'(run_gain)) >>> GAIN_FRAC;
		if (reg_mono) begin
			l = (l + r) >>> 1;
			r = l;
		end
		l = clamp_sample(l);
		r = clamp_sample(r);
		res.out_left = SAMPLE_BITS'(l);
		res.out_right = SAMPLE_BITS'(r);
		res.input_level_peak = '0;
		res.output_level_peak = '0;
		res.buffer_end = f.last;
		if (reg_meter) begin
			if (magnitude(l_in) > in_peak) in_peak = SAMPLE_BITS'(magnitude(l_in));
			if (magnitude(r_in) > in_peak) in_peak = SAMPLE_BITS'(magnitude(r_in));
			if (magnitude(l) > out_peak) out_peak = SAMPLE_BITS'(magnitude(l));
			if (magnitude(r) > out_peak) out_peak = SAMPLE_BITS'(magnitude(r));
			if (f.last) begin
				res.input_level_peak = in_peak;
				res.output_level_peak = out_peak;
				in_peak = '0;
				out_peak = '0;
			end
		end
		buf_start = f.last;
		return res;
	endfunction

	task automatic flag_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", field, got, want);
		mismatch_count++;
	endtask

	// frame driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				expected_results.push_back(apply_gain(tx_frame));
			if (push && full) begin
				// hold the word on the port
			end else if (frames_to_send.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				tx_frame = frames_to_send.pop_front();
				push <= 1'b1;
				left_sample <= tx_frame.left;
				right_sample <= tx_frame.right;
				last_frame <= tx_frame.last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("word with none pending", 0, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_left !== want.out_left)
						flag_mismatch("out_left", out_left, want.out_left);
					if (out_right !== want.out_right)
						flag_mismatch("out_right", out_right, want.out_right);
					if (input_level_peak !== want.input_level_peak)
						flag_mismatch("input_level_peak", input_level_peak,
							want.input_level_peak);
					if (output_level_peak !== want.output_level_peak)
						flag_mismatch("output_level_peak", output_level_peak,
							want.output_level_peak);
					if (buffer_end !== want.buffer_end)
						flag_mismatch("buffer_end", buffer_end, want.buffer_end);
				end
			end
			pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one long receiver stall so both internal queues fill and full rises
	initial begin : rx_long_hold
		int k;
		wait (hold_start);
		@(posedge clk);
		recv_hold <= 1'b1;
		for (k = 0; k < 150; k++)
			@(posedge clk);
		recv_hold <= 1'b0;
	end

	initial begin
		#2000000;
		$display("tb_stereo_gain_ramp_meter_core NOT OK");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TARGET_GAIN: reg_target = val;
			REG_RAMP_FRAMES: reg_ramp = val;
			REG_MONO_OUTPUT: reg_mono = val[0];
			REG_METERING_ENABLE: begin
				reg_meter = val[0];
				in_peak = '0;
				out_peak = '0;
			end
			default: ;
		endcase
	endtask

	task automatic add_frame(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r, input logic last);
		frame_t f;
		f.left = l;
		f.right = r;
		f.last = last;
		frames_to_send.push_back(f);
		frames_queued++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return S_MIN;
			1: return S_MAX;
			2: return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic queue_buffer(int len, logic closed);
		int i;
		for (i = 0; i < len; i++)
			add_frame(pick_sample(), pick_sample(), closed && (i == len - 1));
	endtask

	// waits until every frame went in and every word came out
	task automatic drain();
		while (frames_to_send.size() != 0 || push || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int phase;
		int nbuf;
		int b;
		logic [CFG_DATA_BITS-1:0] val;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: first frame starts the long ramp up from zero
		add_frame(S_MIN, S_MAX, 1'b0);
		add_frame(S_MAX, S_MIN, 1'b0);
		add_frame(-1, 1, 1'b1);
		drain();
		write_reg(REG_TARGET_GAIN, 16'hFFFF);
		write_reg(REG_RAMP_FRAMES, 16'd1);
		write_reg(REG_METERING_ENABLE, 16'd1);
		add_frame(S_MIN, S_MAX, 1'b0);
		add_frame(S_MAX, S_MIN, 1'b0);
		add_frame(-1, 0, 1'b0);
		add_frame(0, 0, 1'b1);
		drain();
		write_reg(REG_MONO_OUTPUT, 16'd1);
		add_frame(S_MIN, S_MIN, 1'b0);
		add_frame(S_MAX, S_MAX, 1'b0);
		add_frame(-1, 0, 1'b0);
		add_frame(S_MIN, S_MAX, 1'b1);
		drain();
		// zero ramp length behaves as one frame
		write_reg(REG_RAMP_FRAMES, 16'd0);
		write_reg(REG_TARGET_GAIN, 16'd0);
		write_reg(REG_MONO_OUTPUT, 16'hFFFE);
		add_frame(S_MAX, S_MIN, 1'b0);
		add_frame(12345, -54321, 1'b1);
		drain();
		write_reg(REG_TARGET_GAIN, 16'd16384);
		write_reg(REG_RAMP_FRAMES, 16'd3);
		add_frame(S_MAX, S_MIN, 1'b0);
		add_frame(-3, 5, 1'b0);
		drain();
		// new target inside an open buffer waits for the next buffer start
		write_reg(REG_TARGET_GAIN, 16'd24576);
		write_reg(8'd200, 16'hFFFF);
		add_frame(S_MIN, S_MAX, 1'b0);
		add_frame(777, -777, 1'b1);
		add_frame(1, -1, 1'b1);
		drain();
		write_reg(REG_METERING_ENABLE, 16'd0);
		add_frame(S_MAX, S_MIN, 1'b0);
		add_frame(-5, 5, 1'b1);

		phase = 0;
		while (frames_queued < TOTAL_FRAMES) begin
			drain();
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 45; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 45; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(5))
					0: val = '0;
					1: val = UNITY_Q15;
					2: val = CFG_DATA_BITS'($urandom_range(65535, 32769));
					default: val = CFG_DATA_BITS'($urandom_range(32768));
				endcase
				write_reg(REG_TARGET_GAIN, val);
			end
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0: val = '0;
					1: val = 16'hFFFF;
					2: val = CFG_DATA_BITS'($urandom_range(300, 1));
					default: val = CFG_DATA_BITS'($urandom_range(6, 1));
				endcase
				write_reg(REG_RAMP_FRAMES, val);
			end
			if ($urandom_range(3) == 0)
				write_reg(REG_MONO_OUTPUT, CFG_DATA_BITS'($urandom));
			if ($urandom_range(3) == 0)
				write_reg(REG_METERING_ENABLE, CFG_DATA_BITS'($urandom));
			if ($urandom_range(15) == 0)
				write_reg(CFG_IDX_BITS'($urandom_range(255, 4)), CFG_DATA_BITS'($urandom));
			if (phase == 3) begin
				send_idle_pct = 0;
				hold_start = 1'b1;
				nbuf = 12;
			end else begin
				nbuf = $urandom_range(6, 2);
			end
			for (b = 0; b < nbuf; b++)
				queue_buffer($urandom_range(8, 1), (b < nbuf - 1) || ($urandom_range(3) != 0));
			phase++;
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_stereo_gain_ramp_meter_core OK");
		else
			$display("tb_stereo_gain_ramp_meter_core NOT OK");
		$finish;
	end

endmodule
